@@ sv/rrol_pkg.sv @@
// Shared types and codes for the round-robin order list.
package rrol_pkg;

	localparam logic CMD_UPDATE  = 1'b0;
	localparam logic CMD_COMPARE = 1'b1;

	localparam logic [1:0] CHG_SAME   = 2'd0;
	localparam logic [1:0] CHG_GROW   = 2'd1;
	localparam logic [1:0] CHG_SHRINK = 2'd2;

	typedef logic [5:0] ucnt_t;

	typedef struct packed {
		logic        cmd;
		logic [15:0] user_id;
		logic [1:0]  block_change;
		logic [15:0] other_user_id;
	} req_item_t;

	typedef struct packed {
		logic  first_goes_before;
		logic  list_full;
		ucnt_t user_count;
	} rsp_item_t;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_SCAN,
		DP_SHUP_CNT,
		DP_SHUP_PA,
		DP_SHDN,
		DP_WR_FRONT_A,
		DP_WR_FRONT_B,
		DP_WR_LAST_A,
		DP_APPEND_A,
		DP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   inc_cnt;
		logic   first_before;
		logic   full;
	} dp_cmd_t;

	localparam dp_cmd_t CMD_NOP = '{op: DP_NOP, inc_cnt: 1'b0, first_before: 1'b0, full: 1'b0};

	typedef struct packed {
		logic       busy;
		logic       out_busy;
		logic       found_a;
		logic       found_b;
		logic       a_first;
		logic       same_id;
		logic       room1;
		logic       room2;
		logic       is_cmp;
		logic [1:0] change;
	} dp_status_t;

endpackage

@@ sv/rrol_req_if.sv @@
// Input channel of the order list: valid, ready and one request item.
interface rrol_req_if;
	logic                valid;
	logic                ready;
	rrol_pkg::req_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ sv/rrol_rsp_if.sv @@
// Output channel of the order list: valid, ready and one result item.
interface rrol_rsp_if;
	logic                valid;
	logic                ready;
	rrol_pkg::rsp_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ sv/rrol_dpath.sv @@
// Datapath of the order list: order memory, scan and shift engine, counters, result register.
module rrol_dpath #(
	parameter int MAX_USERS = 32,
	parameter int ID_BITS   = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  rrol_pkg::req_item_t  item,
	input  rrol_pkg::dp_cmd_t    cmd,
	output rrol_pkg::dp_status_t status,
	output logic                 out_valid,
	input  logic                 out_ready,
	output rrol_pkg::rsp_item_t  out_item
);

	localparam int IDX_W = (MAX_USERS > 2) ? $clog2(MAX_USERS) : 1;
	localparam int CNT_W = $clog2(MAX_USERS + 1);
	localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_USERS);
	localparam logic [CNT_W-1:0] CNT_MAX1 = CNT_W'(MAX_USERS - 1);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

	typedef enum logic [1:0] {M_SCAN, M_UP, M_DOWN} mode_t;

	logic [ID_BITS-1:0] mem [MAX_USERS];
	logic [ID_BITS-1:0] a_q, b_q, rdata_q, wdata;
	logic               is_cmp_q;
	logic [1:0]         change_q;
	logic [CNT_W-1:0]   count_q, cur_q, lim_q;
	logic [IDX_W-1:0]   pa_q, pb_q, pidx_s1, raddr, pidx, waddr;
	logic               found_a_q, found_b_q, run_q, pv_s1, issue, we, start;
	mode_t              mode_q;
	logic               out_valid_q;
	rrol_pkg::rsp_item_t out_q;

	assign issue = run_q && (cur_q != lim_q);

	always_comb begin
		start = cmd.op inside {rrol_pkg::DP_SCAN, rrol_pkg::DP_SHUP_CNT,
			rrol_pkg::DP_SHUP_PA, rrol_pkg::DP_SHDN};
	end

	// Shift up reads below the cursor and writes at it; shift down reads at the cursor
	// and writes one place lower.
	always_comb begin
		case (mode_q)
			M_UP: begin
				raddr = IDX_W'(cur_q - CNT_ONE);
				pidx  = IDX_W'(cur_q);
			end
			M_DOWN: begin
				raddr = IDX_W'(cur_q);
				pidx  = IDX_W'(cur_q - CNT_ONE);
			end
			default: begin
				raddr = IDX_W'(cur_q);
				pidx  = IDX_W'(cur_q);
			end
		endcase
	end

	always_comb begin
		we    = 1'b0;
		waddr = pidx_s1;
		wdata = rdata_q;
		if (pv_s1 && mode_q != M_SCAN) begin
			we = 1'b1;
		end
		case (cmd.op)
			rrol_pkg::DP_WR_FRONT_A: begin
				we    = 1'b1;
				waddr = '0;
				wdata = a_q;
			end
			rrol_pkg::DP_WR_FRONT_B: begin
				we    = 1'b1;
				waddr = '0;
				wdata = b_q;
			end
			rrol_pkg::DP_WR_LAST_A: begin
				we    = 1'b1;
				waddr = IDX_W'(count_q - CNT_ONE);
				wdata = a_q;
			end
			rrol_pkg::DP_APPEND_A: begin
				we    = 1'b1;
				waddr = IDX_W'(count_q);
				wdata = a_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q       <= 1'b0;
			pv_s1       <= 1'b0;
			mode_q      <= M_SCAN;
			cur_q       <= '0;
			lim_q       <= '0;
			count_q     <= '0;
			found_a_q   <= 1'b0;
			found_b_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			pv_s1 <= issue;
			if (start) begin
				run_q <= 1'b1;
				case (cmd.op)
					rrol_pkg::DP_SCAN: begin
						mode_q    <= M_SCAN;
						cur_q     <= '0;
						lim_q     <= count_q;
						found_a_q <= 1'b0;
						found_b_q <= 1'b0;
					end
					rrol_pkg::DP_SHUP_CNT: begin
						mode_q <= M_UP;
						cur_q  <= count_q;
						lim_q  <= '0;
					end
					rrol_pkg::DP_SHUP_PA: begin
						mode_q <= M_UP;
						cur_q  <= CNT_W'(pa_q);
						lim_q  <= '0;
					end
					default: begin
						mode_q <= M_DOWN;
						cur_q  <= CNT_W'(pa_q) + CNT_ONE;
						lim_q  <= count_q;
					end
				endcase
			end else if (run_q) begin
				if (issue) begin
					cur_q <= (mode_q == M_UP) ? cur_q - CNT_ONE : cur_q + CNT_ONE;
				end else begin
					run_q <= 1'b0;
				end
			end
			if (pv_s1 && mode_q == M_SCAN) begin
				if (rdata_q == a_q && !found_a_q) begin
					found_a_q <= 1'b1;
				end
				if (rdata_q == b_q && !found_b_q) begin
					found_b_q <= 1'b1;
				end
			end
			if (cmd.inc_cnt) begin
				count_q <= count_q + CNT_ONE;
			end
			if (cmd.op == rrol_pkg::DP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			a_q      <= ID_BITS'(item.user_id);
			b_q      <= ID_BITS'(item.other_user_id);
			is_cmp_q <= item.cmd;
			change_q <= item.block_change;
		end
		pidx_s1 <= pidx;
		if (pv_s1 && mode_q == M_SCAN) begin
			if (rdata_q == a_q && !found_a_q) begin
				pa_q <= pidx_s1;
			end
			if (rdata_q == b_q && !found_b_q) begin
				pb_q <= pidx_s1;
			end
		end
		if (cmd.op == rrol_pkg::DP_OUT) begin
			out_q.first_goes_before <= cmd.first_before;
			out_q.list_full         <= cmd.full;
			out_q.user_count        <= rrol_pkg::ucnt_t'(count_q);
		end
	end

	always_comb begin
		status.busy     = run_q | pv_s1 | start;
		status.out_busy = out_valid_q & ~out_ready;
		status.found_a  = found_a_q;
		status.found_b  = found_b_q;
		status.a_first  = pa_q < pb_q;
		status.same_id  = a_q == b_q;
		status.room1    = count_q < CNT_MAX;
		status.room2    = count_q < CNT_MAX1;
		status.is_cmp   = is_cmp_q;
		status.change   = change_q;
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

@@ sv/rrol_ctrl.sv @@
// Controller of the order list: sequences scan, shift and write steps for each item.
module rrol_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	output logic                 idle,
	input  rrol_pkg::dp_status_t status,
	output rrol_pkg::dp_cmd_t    cmd
);

	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DECIDE, S_SHIFT, S_WRITE, S_OUT} state_t;

	state_t            state_q;
	rrol_pkg::dp_cmd_t cmd_q;
	rrol_pkg::dp_op_t  wr_op_q;
	logic              inc_q, before_q, full_q, b_pend_q;
	logic              a_ins, b_ins, a_listed, b_listed, cmp_full, cmp_before;

	// Decide the compare outcome from the scan: a goes in front first, then b.
	always_comb begin
		a_ins    = !status.found_a && status.room1;
		b_ins    = !status.same_id && !status.found_b && (a_ins ? status.room2 : status.room1);
		a_listed = status.found_a || a_ins;
		b_listed = status.found_b || b_ins;
		cmp_full = (!status.found_a && !a_ins) ||
			(!status.same_id && !status.found_b && !b_ins);
		if (status.same_id) begin
			cmp_before = 1'b1;
		end else if (!a_listed) begin
			cmp_before = 1'b0;
		end else if (!b_listed) begin
			cmp_before = 1'b1;
		end else if (b_ins) begin
			cmp_before = 1'b0;
		end else if (a_ins) begin
			cmp_before = 1'b1;
		end else begin
			cmp_before = status.a_first;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cmd_q    <= rrol_pkg::CMD_NOP;
			wr_op_q  <= rrol_pkg::DP_NOP;
			inc_q    <= 1'b0;
			before_q <= 1'b0;
			full_q   <= 1'b0;
			b_pend_q <= 1'b0;
		end else begin
			cmd_q <= rrol_pkg::CMD_NOP;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						before_q  <= 1'b0;
						full_q    <= 1'b0;
						b_pend_q  <= 1'b0;
						cmd_q.op  <= rrol_pkg::DP_SCAN;
						state_q   <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (!status.busy) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (status.is_cmp == rrol_pkg::CMD_UPDATE) begin
						if (!status.found_a) begin
							if (!status.room1) begin
								full_q  <= 1'b1;
								state_q <= S_OUT;
							end else if (status.change == rrol_pkg::CHG_GROW) begin
								// A new user that grew lands at the back directly.
								cmd_q.op      <= rrol_pkg::DP_APPEND_A;
								cmd_q.inc_cnt <= 1'b1;
								state_q       <= S_WRITE;
							end else begin
								cmd_q.op <= rrol_pkg::DP_SHUP_CNT;
								wr_op_q  <= rrol_pkg::DP_WR_FRONT_A;
								inc_q    <= 1'b1;
								state_q  <= S_SHIFT;
							end
						end else begin
							case (status.change)
								rrol_pkg::CHG_GROW: begin
									cmd_q.op <= rrol_pkg::DP_SHDN;
									wr_op_q  <= rrol_pkg::DP_WR_LAST_A;
									inc_q    <= 1'b0;
									state_q  <= S_SHIFT;
								end
								rrol_pkg::CHG_SHRINK: begin
									cmd_q.op <= rrol_pkg::DP_SHUP_PA;
									wr_op_q  <= rrol_pkg::DP_WR_FRONT_A;
									inc_q    <= 1'b0;
									state_q  <= S_SHIFT;
								end
								default: begin
									state_q <= S_OUT;
								end
							endcase
						end
					end else begin
						before_q <= cmp_before;
						full_q   <= cmp_full;
						b_pend_q <= a_ins && b_ins;
						if (a_ins) begin
							cmd_q.op <= rrol_pkg::DP_SHUP_CNT;
							wr_op_q  <= rrol_pkg::DP_WR_FRONT_A;
							inc_q    <= 1'b1;
							state_q  <= S_SHIFT;
						end else if (b_ins) begin
							cmd_q.op <= rrol_pkg::DP_SHUP_CNT;
							wr_op_q  <= rrol_pkg::DP_WR_FRONT_B;
							inc_q    <= 1'b1;
							state_q  <= S_SHIFT;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_SHIFT: begin
					if (!status.busy) begin
						cmd_q.op      <= wr_op_q;
						cmd_q.inc_cnt <= inc_q;
						state_q       <= S_WRITE;
					end
				end
				S_WRITE: begin
					if (b_pend_q) begin
						b_pend_q <= 1'b0;
						cmd_q.op <= rrol_pkg::DP_SHUP_CNT;
						wr_op_q  <= rrol_pkg::DP_WR_FRONT_B;
						inc_q    <= 1'b1;
						state_q  <= S_SHIFT;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!status.out_busy) begin
						cmd_q.op           <= rrol_pkg::DP_OUT;
						cmd_q.first_before <= before_q;
						cmd_q.full         <= full_q;
						state_q            <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign idle = state_q == S_IDLE;
	assign cmd  = cmd_q;

endmodule

@@ sv/round_robin_order_list.sv @@
// Top level of the round-robin order list: controller and datapath.
// The block keeps user identifiers in service order in a simple dual-port order memory
// (one read and one write per cycle) and takes one item at a time. An item first
// walks the whole list to find its users, then, where needed, moves entries one place
// per cycle to open a slot at the front or close a gap, and a compare that inserts
// two new users does this twice. The result sits in an output register, so the next
// item is taken while it waits.
module round_robin_order_list #(
	parameter int MAX_USERS = 32,
	parameter int ID_BITS   = 16
) (
	input logic       clk,
	input logic       arst_n,
	rrol_req_if.sink   req,
	rrol_rsp_if.source rsp
);

	logic                 accept;
	logic                 idle;
	rrol_pkg::dp_cmd_t    cmd;
	rrol_pkg::dp_status_t status;

	assign req.ready = idle;
	assign accept    = req.valid & idle;

	rrol_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.idle   (idle),
		.status (status),
		.cmd    (cmd)
	);

	rrol_dpath #(
		.MAX_USERS (MAX_USERS),
		.ID_BITS   (ID_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (req.data),
		.cmd       (cmd),
		.status    (status),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.out_item  (rsp.data)
	);

endmodule

@@ verif/tb_round_robin_order_list.sv @@
// Testbench of the round-robin order list: directed, pooled random, output hold-off and full-list item checks.
module tb_round_robin_order_list;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_USERS   = 32;
	localparam int STALL_LIMIT = 4000;
	localparam int TAIL_CYCLES = 3 * NUM_USERS + 30;
	localparam int POOL_USERS  = 30;
	localparam int HOLD_CYCLES = 400;

	// Change code outside the defined set; the block treats it as no move.
	localparam logic [1:0] CHG_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n;

	rrol_req_if req_ch();
	rrol_rsp_if rsp_ch();

	round_robin_order_list #(.MAX_USERS(NUM_USERS), .ID_BITS(16)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// Service order as the block should hold it, front first.
	logic [15:0] svc_order[$];
	logic [15:0] id_pool[$];
	rrol_pkg::rsp_item_t order_rsp_q[$];
	rrol_pkg::rsp_item_t head_rsp;

	int unsigned src_idle_pct   = 0;
	int unsigned sink_stall_pct = 0;
	int unsigned idle_cycles    = 0;
	int unsigned mismatch_cnt   = 0;
	bit          hold_on;
	event        hold_ev;

	initial begin
		forever #5 clk = ~clk;
	end

	// Holds the receiver off for a fixed stretch each time a test asks for it.
	initial begin
		hold_on <= 1'b0;
		forever begin
			@(hold_ev);
			hold_on <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_on <= 1'b0;
		end
	end

	function automatic int find_user(logic [15:0] id);
		foreach (svc_order[i]) begin
			if (svc_order[i] == id) return i;
		end
		return -1;
	endfunction

	// Puts an unlisted user at the front; returns 0 when the list has no room.
	function automatic bit admit_user(logic [15:0] id);
		if (find_user(id) >= 0) return 1'b1;
		if (svc_order.size() >= NUM_USERS) return 1'b0;
		svc_order = {id, svc_order};
		return 1'b1;
	endfunction

	function automatic rrol_pkg::rsp_item_t rank_step(rrol_pkg::req_item_t it);
		rrol_pkg::rsp_item_t r;
		int pos;
		int pa;
		int pb;
		r = '0;
		if (it.cmd == rrol_pkg::CMD_UPDATE) begin
			if (!admit_user(it.user_id)) begin
				r.list_full = 1'b1;
			end else if (it.block_change == rrol_pkg::CHG_GROW ||
				it.block_change == rrol_pkg::CHG_SHRINK) begin
				pos = find_user(it.user_id);
				svc_order.delete(pos);
				if (it.block_change == rrol_pkg::CHG_GROW) svc_order = {svc_order, it.user_id};
				else svc_order = {it.user_id, svc_order};
			end
		end else begin
			if (!admit_user(it.user_id)) r.list_full = 1'b1;
			if (!admit_user(it.other_user_id)) r.list_full = 1'b1;
			if (it.user_id == it.other_user_id) begin
				r.first_goes_before = 1'b1;
			end else begin
				pa = find_user(it.user_id);
				pb = find_user(it.other_user_id);
				// A user left out of a full list ranks after every listed user.
				r.first_goes_before = (pa >= 0) && (pb < 0 || pa < pb);
			end
		end
		r.user_count = rrol_pkg::ucnt_t'(svc_order.size());
		return r;
	endfunction

	function automatic rrol_pkg::req_item_t update_item(logic [15:0] id, logic [1:0] chg);
		rrol_pkg::req_item_t it;
		it.cmd           = rrol_pkg::CMD_UPDATE;
		it.user_id       = id;
		it.block_change  = chg;
		it.other_user_id = 16'($urandom);
		return it;
	endfunction

	function automatic rrol_pkg::req_item_t compare_item(logic [15:0] a, logic [15:0] b);
		rrol_pkg::req_item_t it;
		it.cmd           = rrol_pkg::CMD_COMPARE;
		it.user_id       = a;
		it.block_change  = 2'($urandom);
		it.other_user_id = b;
		return it;
	endfunction

	function automatic rrol_pkg::req_item_t pool_item();
		logic [15:0] a;
		logic [15:0] b;
		a = id_pool[$urandom_range(id_pool.size() - 1)];
		b = ($urandom_range(9) == 0) ? a : id_pool[$urandom_range(id_pool.size() - 1)];
		if ($urandom_range(1) == 1) return compare_item(a, b);
		return update_item(a, 2'($urandom));
	endfunction

	// Mostly listed users, some fresh ones that a full list must drop.
	function automatic logic [15:0] any_id();
		if ($urandom_range(99) < 70) return svc_order[$urandom_range(svc_order.size() - 1)];
		return 16'($urandom);
	endfunction

	function automatic rrol_pkg::req_item_t full_item();
		logic [15:0] a;
		logic [15:0] b;
		a = any_id();
		b = ($urandom_range(9) == 0) ? a : any_id();
		if ($urandom_range(1) == 1) return compare_item(a, b);
		return update_item(a, 2'($urandom));
	endfunction

	task automatic send_item(input rrol_pkg::req_item_t it);
		while ($urandom_range(99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data  <= it;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		order_rsp_q = {order_rsp_q, rank_step(it)};
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (order_rsp_q.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed();
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		send_item(compare_item(16'h0000, 16'h0000));
		send_item(compare_item(16'hFFFF, 16'h1234));
		send_item(compare_item(16'h1234, 16'hFFFF));
		send_item(compare_item(16'h0000, 16'hFFFF));
		send_item(update_item(16'h5555, rrol_pkg::CHG_SAME));
		send_item(update_item(16'hAAAA, rrol_pkg::CHG_GROW));
		send_item(update_item(16'h00FF, rrol_pkg::CHG_SHRINK));
		send_item(update_item(16'h0F0F, CHG_UNUSED));
		send_item(update_item(16'h5555, rrol_pkg::CHG_GROW));
		send_item(update_item(16'h0000, rrol_pkg::CHG_SHRINK));
		send_item(update_item(16'hFFFF, CHG_UNUSED));
		send_item(update_item(16'hFFFF, rrol_pkg::CHG_SAME));
		send_item(compare_item(16'h5555, 16'h0000));
		send_item(compare_item(16'h0000, 16'h5555));
		send_item(compare_item(16'hAAAA, 16'hAAAA));
		send_item(compare_item(16'hF0F0, 16'h0000));
		send_item(compare_item(16'h0000, 16'h7777));
		send_item(update_item(16'h0000, rrol_pkg::CHG_GROW));
		send_item(update_item(16'h0000, rrol_pkg::CHG_GROW));
		send_item(update_item(16'hAAAA, rrol_pkg::CHG_SHRINK));
		send_item(update_item(16'hAAAA, rrol_pkg::CHG_SHRINK));
		wait_drained();
	endtask

	// Random moves and compares over a pool that stays below the list size.
	task automatic test_service_rotation();
		logic [15:0] id;
		id_pool = svc_order;
		while (id_pool.size() < POOL_USERS) begin
			id = 16'($urandom);
			if (!(id inside {id_pool})) id_pool = {id_pool, id};
		end
		src_idle_pct = 0;  sink_stall_pct = 0;
		repeat (340) send_item(pool_item());
		wait_drained();
		src_idle_pct = 86; sink_stall_pct = 0;
		repeat (340) send_item(pool_item());
		src_idle_pct = 0;  sink_stall_pct = 86;
		repeat (340) send_item(pool_item());
		wait_drained();
		src_idle_pct = 21; sink_stall_pct = 21;
		repeat (340) send_item(pool_item());
		wait_drained();
	endtask

	// The receiver holds off while items keep coming, so the input must stall.
	task automatic test_output_holdoff();
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		-> hold_ev;
		repeat (60) send_item(pool_item());
		wait_drained();
	endtask

	task automatic test_full_list();
		logic [15:0] id;
		src_idle_pct   = 21;
		sink_stall_pct = 21;
		while (svc_order.size() < NUM_USERS) begin
			id = 16'($urandom);
			if (find_user(id) < 0) send_item(update_item(id, 2'($urandom)));
		end
		send_item(update_item(16'hBEEF, rrol_pkg::CHG_GROW));
		send_item(compare_item(16'hC0DE, 16'hD00D));
		send_item(compare_item(16'hC0DE, 16'hC0DE));
		send_item(compare_item(svc_order[0], 16'hD00D));
		send_item(compare_item(16'hD00D, svc_order[0]));
		repeat (400) send_item(full_item());
		wait_drained();
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (order_rsp_q.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("Result without pending item: before=%0b full=%0b count=%0d",
						rsp_ch.data.first_goes_before, rsp_ch.data.list_full,
						rsp_ch.data.user_count);
			end else begin
				head_rsp = order_rsp_q.pop_front();
				if (rsp_ch.data.first_goes_before !== head_rsp.first_goes_before ||
				    rsp_ch.data.list_full !== head_rsp.list_full ||
				    rsp_ch.data.user_count !== head_rsp.user_count) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("Mismatch (exp/got): before %0b/%0b full %0b/%0b count %0d/%0d",
							head_rsp.first_goes_before, rsp_ch.data.first_goes_before,
							head_rsp.list_full, rsp_ch.data.list_full,
							head_rsp.user_count, rsp_ch.data.user_count);
				end
			end
		end
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else if (hold_on) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		arst_n       <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.data  <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_service_rotation();
		test_output_holdoff();
		test_full_list();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0 && order_rsp_q.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
